// ===== rtl/core/pirhd_pkg.sv =====
package pirhd_pkg;

   localparam int MAX_TARGETS = 256;
   localparam int TGT_IDX_W   = $clog2(MAX_TARGETS);
   localparam int TGT_CNT_W   = $clog2(MAX_TARGETS + 1);

   localparam logic signed [23:0] HEALTH_MIN = 24'sh800000;

   typedef enum logic [0:0] {
      OP_WRITE = 1'b0,
      OP_QUERY = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_UPDATE,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic signed [15:0] x;
      logic signed [15:0] y;
      logic        [15:0] width;
      logic        [15:0] height;
      logic signed [23:0] health;
   } entry_type;

endpackage

// ===== rtl/core/pirhd_req_if.sv =====
interface pirhd_req_if;
   logic               valid;
   logic               ready;
   logic               operation;
   logic        [7:0]  target_index;
   logic signed [15:0] coord_x;
   logic signed [15:0] coord_y;
   logic        [15:0] rect_width;
   logic        [15:0] rect_height;
   logic signed [23:0] initial_health;
   logic        [15:0] damage;
   logic        [11:0] bullet_index;

   modport source (
      output valid, operation, target_index, coord_x, coord_y, rect_width,
             rect_height, initial_health, damage, bullet_index,
      input  ready
   );

   modport sink (
      input  valid, operation, target_index, coord_x, coord_y, rect_width,
             rect_height, initial_health, damage, bullet_index,
      output ready
   );
endinterface

// ===== rtl/core/pirhd_rsp_if.sv =====
interface pirhd_rsp_if;
   logic               valid;
   logic               ready;
   logic               hit;
   logic        [7:0]  hit_target;
   logic        [11:0] hit_bullet;
   logic signed [23:0] health_after;

   modport source (
      output valid, hit, hit_target, hit_bullet, health_after,
      input  ready
   );

   modport sink (
      input  valid, hit, hit_target, hit_bullet, health_after,
      output ready
   );
endinterface

// ===== rtl/core/point_in_rect_hit_and_damage_unit.sv =====
// Target table with point-in-rectangle hit test and damage.
//
// req_if carries items. A write item (operation 0) stores corner, size and
// health of one entry and is done in the cycle it is accepted; it gives no
// result. A query item (operation 1) scans entries 0 .. target_count-1 in
// order and reports the first one whose open interior holds the point.
// On a hit the entry's health drops by damage, floored at the signed minimum.
// Every query gives one result item on rsp_if.
// csr_wr_en/csr_wr_data write target_count (values above 256 scan 256).
//
// A query steps through scan, then on a hit an update that writes the new
// health back, then a finish step that loads the output register. The scan
// runs one entry per cycle through the single read port of the table memory,
// feeding one shared compare unit. req_if.ready is high only while no query
// is in flight, so a query holds off the input until its result is loaded;
// a write does not hold it off.
// The result sits in an output register: the next item is taken while it
// waits, and a following query holds its result until rsp_if.ready.
// Reset clears target_count, the sequencer and the output register; table
// contents are undefined until written.
module point_in_rect_hit_and_damage_unit
   import pirhd_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   pirhd_req_if.sink            req_if,
   pirhd_rsp_if.source          rsp_if,
   input  logic                 csr_wr_en,
   input  logic [TGT_CNT_W-1:0] csr_wr_data
);

   // Table memory
   entry_type mem [MAX_TARGETS];

   logic                 wr_en;
   logic [TGT_IDX_W-1:0] wr_addr;
   entry_type            wr_data;
   logic                 rd_en;
   logic [TGT_IDX_W-1:0] rd_addr;
   entry_type            rd_data_ff;

   // Control and scan state
   state_type            state_ff, state_in;
   logic [TGT_CNT_W-1:0] count_ff;
   logic [TGT_CNT_W-1:0] limit_ff, limit_in;
   logic [TGT_CNT_W-1:0] issue_ff, issue_in;
   logic                 rd_vld_ff, rd_vld_in;
   logic [TGT_IDX_W-1:0] rd_idx_ff, rd_idx_in;

   // Query payload
   logic signed [15:0]   pt_x_ff, pt_x_in;
   logic signed [15:0]   pt_y_ff, pt_y_in;
   logic        [15:0]   dmg_ff, dmg_in;
   logic        [11:0]   bullet_ff, bullet_in;

   // Pending result
   logic                 res_hit_ff, res_hit_in;
   logic [TGT_IDX_W-1:0] res_tgt_ff, res_tgt_in;
   logic signed [23:0]   res_health_ff, res_health_in;

   // Output register
   logic                 rsp_vld_ff, rsp_vld_in;
   logic                 rsp_hit_ff, rsp_hit_in;
   logic        [7:0]    rsp_tgt_ff, rsp_tgt_in;
   logic        [11:0]   rsp_bullet_ff, rsp_bullet_in;
   logic signed [23:0]   rsp_health_ff, rsp_health_in;

   // Shared compare unit
   logic signed [17:0]   x_end, y_end;
   logic signed [17:0]   px_ext, py_ext;
   logic                 pt_in_rect;
   logic                 hit_now;
   logic signed [24:0]   health_diff;
   logic signed [23:0]   health_new;

   logic                 req_fire;
   logic                 rsp_load;
   logic                 wr_in_range;

   assign req_fire = req_if.valid && req_if.ready;

   assign px_ext = {{2{pt_x_ff[15]}}, pt_x_ff};
   assign py_ext = {{2{pt_y_ff[15]}}, pt_y_ff};
   assign x_end  = {{2{rd_data_ff.x[15]}}, rd_data_ff.x} + {2'b00, rd_data_ff.width};
   assign y_end  = {{2{rd_data_ff.y[15]}}, rd_data_ff.y} + {2'b00, rd_data_ff.height};
   assign pt_in_rect = (pt_x_ff > rd_data_ff.x) && (px_ext < x_end) &&
                       (pt_y_ff > rd_data_ff.y) && (py_ext < y_end);
   assign hit_now = (state_ff == ST_SCAN) && rd_vld_ff && pt_in_rect;

   // Underflow shows as the two top bits of the difference disagreeing
   assign health_diff = {rd_data_ff.health[23], rd_data_ff.health} - {9'd0, dmg_ff};
   assign health_new  = (health_diff[24] != health_diff[23]) ? HEALTH_MIN
                                                              : health_diff[23:0];

   assign wr_in_range = {1'b0, req_if.target_index} < 9'(MAX_TARGETS);

   always_comb begin
      state_in      = state_ff;
      limit_in      = limit_ff;
      issue_in      = issue_ff;
      rd_idx_in     = rd_idx_ff;
      pt_x_in       = pt_x_ff;
      pt_y_in       = pt_y_ff;
      dmg_in        = dmg_ff;
      bullet_in     = bullet_ff;
      res_hit_in    = res_hit_ff;
      res_tgt_in    = res_tgt_ff;
      res_health_in = res_health_ff;
      req_if.ready  = 1'b0;
      wr_en         = 1'b0;
      wr_addr       = TGT_IDX_W'(req_if.target_index);
      wr_data       = '{x: req_if.coord_x, y: req_if.coord_y,
                        width: req_if.rect_width, height: req_if.rect_height,
                        health: req_if.initial_health};
      rd_en         = 1'b0;
      rd_addr       = issue_ff[TGT_IDX_W-1:0];
      rsp_load      = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            req_if.ready = 1'b1;
            if (req_fire) begin
               if (req_if.operation == OP_WRITE) begin
                  wr_en = wr_in_range;
               end else begin
                  pt_x_in   = req_if.coord_x;
                  pt_y_in   = req_if.coord_y;
                  dmg_in    = req_if.damage;
                  bullet_in = req_if.bullet_index;
                  limit_in  = (count_ff > TGT_CNT_W'(MAX_TARGETS)) ?
                              TGT_CNT_W'(MAX_TARGETS) : count_ff;
                  issue_in  = '0;
                  state_in  = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            if (hit_now) begin
               // hold rd_data_ff: no read this cycle
               state_in = ST_UPDATE;
            end else if (issue_ff == limit_ff && !rd_vld_ff) begin
               res_hit_in    = 1'b0;
               res_tgt_in    = '0;
               res_health_in = '0;
               state_in      = ST_FINISH;
            end else if (issue_ff < limit_ff) begin
               rd_en     = 1'b1;
               rd_idx_in = issue_ff[TGT_IDX_W-1:0];
               issue_in  = issue_ff + 1'b1;
            end
         end
         ST_UPDATE: begin
            wr_en          = 1'b1;
            wr_addr        = rd_idx_ff;
            wr_data        = rd_data_ff;
            wr_data.health = health_new;
            res_hit_in     = 1'b1;
            res_tgt_in     = rd_idx_ff;
            res_health_in  = health_new;
            state_in       = ST_FINISH;
         end
         ST_FINISH: begin
            if (!rsp_vld_ff || rsp_if.ready) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      rd_vld_in = rd_en;

      rsp_vld_in    = rsp_vld_ff && !rsp_if.ready;
      rsp_hit_in    = rsp_hit_ff;
      rsp_tgt_in    = rsp_tgt_ff;
      rsp_bullet_in = rsp_bullet_ff;
      rsp_health_in = rsp_health_ff;
      if (rsp_load) begin
         rsp_vld_in    = 1'b1;
         rsp_hit_in    = res_hit_ff;
         rsp_tgt_in    = 8'(res_tgt_ff);
         rsp_bullet_in = bullet_ff;
         rsp_health_in = res_health_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         count_ff   <= '0;
         rd_vld_ff  <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         rd_vld_ff  <= rd_vld_in;
         rsp_vld_ff <= rsp_vld_in;
         if (csr_wr_en) begin
            count_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      limit_ff      <= limit_in;
      issue_ff      <= issue_in;
      rd_idx_ff     <= rd_idx_in;
      pt_x_ff       <= pt_x_in;
      pt_y_ff       <= pt_y_in;
      dmg_ff        <= dmg_in;
      bullet_ff     <= bullet_in;
      res_hit_ff    <= res_hit_in;
      res_tgt_ff    <= res_tgt_in;
      res_health_ff <= res_health_in;
      rsp_hit_ff    <= rsp_hit_in;
      rsp_tgt_ff    <= rsp_tgt_in;
      rsp_bullet_ff <= rsp_bullet_in;
      rsp_health_ff <= rsp_health_in;
   end

   assign rsp_if.valid        = rsp_vld_ff;
   assign rsp_if.hit          = rsp_hit_ff;
   assign rsp_if.hit_target   = rsp_tgt_ff;
   assign rsp_if.hit_bullet   = rsp_bullet_ff;
   assign rsp_if.health_after = rsp_health_ff;

   a_query_blocks_input: assert property (@(posedge clock) disable iff (reset)
      req_fire && req_if.operation == OP_QUERY |=> !req_if.ready)
      else $error("input taken while a query is in flight");

   a_update_after_hit: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_UPDATE |-> $past(hit_now))
      else $error("health write-back without a hit");

   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SCAN |-> issue_ff <= limit_ff)
      else $error("scan ran past the entry count");

   a_result_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_vld_ff) |-> $past(state_ff == ST_FINISH))
      else $error("result item raised outside the finish step");

   a_miss_fields_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_vld_ff && !rsp_hit_ff |-> rsp_tgt_ff == 8'd0 && rsp_health_ff == 24'sd0)
      else $error("miss result carries a target or health");

endmodule
